// ===== rtl/crm_pkg.sv =====
package crm_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 256;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 8;
  localparam int NR_W      = 7;
  localparam int NC_W      = 9;
  localparam int SMP_W     = 16;
  localparam int SMP_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int SUM_W     = 24;
  localparam int EN_W      = 48;
  localparam int ACC_W     = 40;
  localparam int STEP_W    = 6;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] col_t;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_ST_CLR  = 14'b00000000000010,
    S_ST_ACC  = 14'b00000000000100,
    S_ST_DRN  = 14'b00000000001000,
    S_ST_FIN  = 14'b00000000010000,
    S_PR_LD   = 14'b00000000100000,
    S_PR_CHK  = 14'b00000001000000,
    S_PR_DOT  = 14'b00000010000000,
    S_PR_DRN  = 14'b00000100000000,
    S_PR_C    = 14'b00001000000000,
    S_PR_MUL  = 14'b00010000000000,
    S_PR_DIV  = 14'b00100000000000,
    S_PR_SQ   = 14'b01000000000000,
    S_PR_EMIT = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic             wr_en;
    row_t             wr_row;
    col_t             wr_col;
    logic [SMP_W-1:0] wr_data;
    logic             rd_en;
    row_t             rd_row_a;
    row_t             rd_row_b;
    col_t             rd_col;
    logic             sq_sel;
    logic             acc_clr;
    logic [NC_W-1:0]  ncols;
    logic             fin_mul;
    logic             fin_wr;
    logic             st_rd;
    logic             c_mul;
    logic             c_sub;
    logic             mul_clr;
    logic             mul_step;
    logic             mul_sel;
    logic [1:0]       mul_dig;
    logic             div_init;
    logic             div_step;
    logic             div_first;
    logic             sq_init;
    logic             sq_step;
    logic [4:0]       sq_bit;
    logic             emit;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/crm_dp.sv =====
module crm_dp import crm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // row_first, row_second, correlation, zero fill
  output logic        m_tuser,  // degenerate
  output logic        m_tlast
);

  logic [SMP_W-1:0] smem [SMP_DEPTH];
  logic signed [SUM_W-1:0] sum_mem [MAX_ROWS];
  logic signed [EN_W-1:0]  en_mem  [MAX_ROWS];

  logic signed [15:0] xa, xb, xa_d;
  logic signed [31:0] prod;
  logic               v1, v2, sq_d;
  logic signed [ACC_W-1:0] acc;
  logic signed [SUM_W-1:0] ssum;
  logic signed [49:0] nq;
  logic signed [47:0] ss;
  logic signed [SUM_W-1:0] si, sj;
  logic signed [EN_W-1:0]  ei, ej;
  logic signed [49:0] ndot, cval;
  logic signed [47:0] sisj;
  logic        csign;
  logic [47:0] cabs;
  logic [95:0] c2, pq, rem, trial, pp_sh;
  logic [47:0] op_a, op_b;
  logic [15:0] dig;
  logic [63:0] pp;
  logic [32:0] quo;
  logic [16:0] t, t_try;
  logic [33:0] t_sq;
  logic [17:0] mag_r, neg_m;
  logic [16:0] mag;
  logic signed [15:0] corr;
  row_t        r_first, r_second;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      smem[{cmd.wr_row, cmd.wr_col}] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      xa <= smem[{cmd.rd_row_a, cmd.rd_col}];
      xb <= smem[{cmd.rd_row_b, cmd.rd_col}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) sq_d <= cmd.sq_sel;
    prod <= xa * (sq_d ? xa : xb);
    xa_d <= xa;
    if (cmd.acc_clr) begin
      acc  <= '0;
      ssum <= '0;
    end else if (v2) begin
      acc  <= acc + {{(ACC_W-32){prod[31]}}, prod};
      ssum <= ssum + {{(SUM_W-16){xa_d[15]}}, xa_d};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_mul) begin
      nq <= $signed({1'b0, cmd.ncols}) * acc;
      ss <= ssum * ssum;
    end
    if (cmd.fin_wr) begin
      sum_mem[cmd.rd_row_a] <= ssum;
      en_mem[cmd.rd_row_a]  <= EN_W'(nq - {{2{ss[47]}}, ss});
    end
    if (cmd.st_rd) begin
      si <= sum_mem[cmd.rd_row_a];
      sj <= sum_mem[cmd.rd_row_b];
      ei <= en_mem[cmd.rd_row_a];
      ej <= en_mem[cmd.rd_row_b];
      r_first  <= cmd.rd_row_a;
      r_second <= cmd.rd_row_b;
    end
  end

  assign sts.degen = (ei <= 0) || (ej <= 0);

  assign cval = ndot - {{2{sisj[47]}}, sisj};

  always_ff @(posedge clk) begin
    if (cmd.c_mul) begin
      ndot <= $signed({1'b0, cmd.ncols}) * acc;
      sisj <= si * sj;
    end
    if (cmd.c_sub) begin
      csign <= cval[49];
      cabs  <= cval[49] ? 48'(-cval) : 48'(cval);
    end
  end

  always_comb begin
    op_a  = cmd.mul_sel ? 48'(ei) : cabs;
    op_b  = cmd.mul_sel ? 48'(ej) : cabs;
    dig   = op_b[{cmd.mul_dig, 4'b0000} +: 16];
    pp    = op_a * dig;
    pp_sh = 96'(pp) << {cmd.mul_dig, 4'b0000};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_clr) begin
      c2 <= '0;
      pq <= '0;
    end else if (cmd.mul_step) begin
      if (cmd.mul_sel) pq <= pq + pp_sh;
      else c2 <= c2 + pp_sh;
    end
  end

  assign trial = {rem[94:0], cmd.div_first ? c2[0] : 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= {1'b0, c2[95:1]};
      quo <= '0;
    end else if (cmd.div_step) begin
      if (trial >= pq) begin
        rem <= trial - pq;
        quo <= {quo[31:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[31:0], 1'b0};
      end
    end
  end

  assign t_try = t | (17'd1 << cmd.sq_bit);
  assign t_sq  = t_try * t_try;

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      t <= '0;
    end else if (cmd.sq_step && (t_sq <= {1'b0, quo})) begin
      t <= t_try;
    end
  end

  always_comb begin
    mag_r = 18'(t) + 18'd1;
    mag   = mag_r[17:1];
    neg_m = 18'd0 - {1'b0, mag};
    if (sts.degen) begin
      corr = '0;
    end else if (csign) begin
      corr = (mag > 17'd32768) ? 16'sh8000 : $signed(neg_m[15:0]);
    end else begin
      corr = (mag > 17'd32767) ? 16'sh7fff : $signed(mag[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'b0000, corr, r_second, r_first};
      m_tuser <= sts.degen;
      m_tlast <= cmd.out_last;
    end
  end

  assign sts.out_busy = m_tvalid && !m_tready;

endmodule

// ===== rtl/crm_ctrl.sv =====
module crm_ctrl import crm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // row, col, sample, zero fill
  input  logic        s_tuser,  // action
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  output cmd_t        cmd,
  input  sts_t        sts
);

  state_t state, state_next;
  logic [NR_W-1:0]   num_rows, nr;
  logic [NC_W-1:0]   num_cols, nc;
  logic              stats_valid, stats_valid_next;
  row_t              qrow, qrow_next, cur, cur_next;
  col_t              k, k_next;
  logic [STEP_W-1:0] step, step_next;
  row_t              in_row;
  logic              k_end, cur_end;

  assign in_row = s_tdata[5:0];

  always_comb begin
    nr = num_rows;
    if (num_rows == '0) nr = NR_W'(1);
    else if (num_rows > NR_W'(MAX_ROWS)) nr = NR_W'(MAX_ROWS);
    nc = num_cols;
    if (num_cols == '0) nc = NC_W'(1);
    else if (num_cols > NC_W'(MAX_COLS)) nc = NC_W'(MAX_COLS);
  end

  assign k_end   = ({1'b0, k} == nc - NC_W'(1));
  assign cur_end = ({1'b0, cur} + NR_W'(1) == nr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stats_valid <= 1'b0;
      num_rows    <= NR_W'(64);
      num_cols    <= NC_W'(256);
    end else begin
      state       <= state_next;
      stats_valid <= stats_valid_next;
      if (cfg_we) begin
        stats_valid <= 1'b0;
        if (cfg_index == REG_NUM_ROWS) num_rows <= cfg_data[NR_W-1:0];
        else num_cols <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    qrow <= qrow_next;
    cur  <= cur_next;
    k    <= k_next;
    step <= step_next;
  end

  always_comb begin
    state_next       = state;
    stats_valid_next = stats_valid;
    qrow_next        = qrow;
    cur_next         = cur;
    k_next           = k;
    step_next        = step;
    s_tready         = 1'b0;
    cmd              = '0;
    cmd.wr_row       = in_row;
    cmd.wr_col       = s_tdata[13:6];
    cmd.wr_data      = s_tdata[29:14];
    cmd.ncols        = nc;
    cmd.rd_row_a     = qrow;
    cmd.rd_row_b     = cur;
    cmd.rd_col       = k;
    cmd.out_last     = cur_end;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == ACT_LOAD) begin
            cmd.wr_en        = 1'b1;
            stats_valid_next = 1'b0;
          end else if ({1'b0, in_row} < nr) begin
            qrow_next = in_row;
            if (!stats_valid) begin
              cur_next   = '0;
              state_next = S_ST_CLR;
            end else begin
              cur_next   = in_row;
              state_next = S_PR_LD;
            end
          end
        end
      end
      S_ST_CLR: begin
        cmd.acc_clr = 1'b1;
        k_next      = '0;
        state_next  = S_ST_ACC;
      end
      S_ST_ACC: begin
        cmd.rd_en    = 1'b1;
        cmd.sq_sel   = 1'b1;
        cmd.rd_row_a = cur;
        k_next       = k + COL_W'(1);
        if (k_end) begin
          step_next  = '0;
          state_next = S_ST_DRN;
        end
      end
      S_ST_DRN: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(1)) begin
          step_next  = '0;
          state_next = S_ST_FIN;
        end
      end
      S_ST_FIN: begin
        cmd.rd_row_a = cur;
        step_next    = step + STEP_W'(1);
        if (step == '0) begin
          cmd.fin_mul = 1'b1;
        end else begin
          cmd.fin_wr = 1'b1;
          if (cur_end) begin
            stats_valid_next = 1'b1;
            cur_next         = qrow;
            state_next       = S_PR_LD;
          end else begin
            cur_next   = cur + ROW_W'(1);
            state_next = S_ST_CLR;
          end
        end
      end
      S_PR_LD: begin
        cmd.st_rd   = 1'b1;
        cmd.acc_clr = 1'b1;
        k_next      = '0;
        state_next  = S_PR_CHK;
      end
      S_PR_CHK: begin
        state_next = sts.degen ? S_PR_EMIT : S_PR_DOT;
      end
      S_PR_DOT: begin
        cmd.rd_en = 1'b1;
        k_next    = k + COL_W'(1);
        if (k_end) begin
          step_next  = '0;
          state_next = S_PR_DRN;
        end
      end
      S_PR_DRN: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(1)) begin
          step_next  = '0;
          state_next = S_PR_C;
        end
      end
      S_PR_C: begin
        step_next = step + STEP_W'(1);
        if (step == '0) begin
          cmd.c_mul = 1'b1;
        end else begin
          cmd.c_sub   = 1'b1;
          cmd.mul_clr = 1'b1;
          step_next   = '0;
          state_next  = S_PR_MUL;
        end
      end
      S_PR_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel  = (step >= STEP_W'(3));
        cmd.mul_dig  = (step >= STEP_W'(3)) ? 2'(step - STEP_W'(3)) : 2'(step);
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(5)) begin
          step_next  = '0;
          state_next = S_PR_DIV;
        end
      end
      S_PR_DIV: begin
        step_next = step + STEP_W'(1);
        if (step == '0) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.div_step  = 1'b1;
          cmd.div_first = (step == STEP_W'(1));
          if (step == STEP_W'(33)) begin
            step_next  = '0;
            state_next = S_PR_SQ;
          end
        end
      end
      S_PR_SQ: begin
        step_next  = step + STEP_W'(1);
        cmd.sq_bit = 5'(STEP_W'(17) - step);
        if (step == '0) begin
          cmd.sq_init = 1'b1;
        end else begin
          cmd.sq_step = 1'b1;
          if (step == STEP_W'(17)) begin
            step_next  = '0;
            state_next = S_PR_EMIT;
          end
        end
      end
      S_PR_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          if (cur_end) begin
            state_next = S_IDLE;
          end else begin
            cur_next   = cur + ROW_W'(1);
            state_next = S_PR_LD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/row_correlation_matrix.sv =====
// Row correlation matrix.
// Input stream s_*: s_tuser selects the action. A load (s_tuser 0) writes one
// Q8.8 sample of s_tdata at (row, col). A query (s_tuser 1) of row i returns
// the Q1.15 Pearson correlation of row i with each row j = i .. num_rows-1
// on m_*, in increasing j; m_tlast marks the final pair and m_tuser flags a
// row with zero variance (correlation 0). A query of a row outside num_rows
// returns nothing.
// Configuration: cfg_we with cfg_index 0 (num_rows) or 1 (num_cols).
// The first query after a load or a register write recomputes the row
// statistics, streaming every sample through the single multiply-accumulate
// unit. Each pair then runs the dot product on that MAC, a 33-step restoring
// divider and a 17-step square-root unit; a pair with zero variance skips
// the dot product, divider and square root. One item is worked at a time;
// s_tready is high only when idle.
// Results sit in an output register; while m_tready is low the next pair is
// computed and held until that register frees up.
// Reset (rst, synchronous) restores num_rows 64 and num_cols 256, empties
// the output register and marks the statistics stale; samples stay.
module row_correlation_matrix import crm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // row[5:0], col[13:6], sample[29:14], zero fill
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // row_first[5:0], row_second[11:6], correlation[27:12]
  output logic        m_tuser,   // degenerate
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  crm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  crm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== rtl/crm_checker.sv =====
module crm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[27:12] == 16'd0)
    else $error("degenerate pair with nonzero correlation");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:6] >= m_tdata[5:0])
    else $error("second row below first row");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind row_correlation_matrix crm_checker u_chk (.*);
